// File: design/positional_list_engine_assert.svh
// Assertion macros for the positional list engine module.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define PLE_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: design/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine.
package ple_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 6;
	localparam int REQ_W        = 3;
	localparam int ST_W         = 2;
	localparam int CAPACITY_DEF = 32;

	localparam logic [REQ_W-1:0] REQ_GET    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic              load;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} ple_cmd_t;

endpackage

// File: design/ple_cell.sv
// One storage cell of the list: holds one element and shifts with its neighbors.
// Depends on ple_pkg for the command struct and widths.
module ple_cell import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                                clk,
	input  ple_cmd_t                            cmd,
	input  logic [$clog2(CAPACITY+1)-1:0]       count,
	input  logic [DATA_W-1:0]                   left,
	input  logic [DATA_W-1:0]                   right,
	output logic [DATA_W-1:0]                   elem,
	output logic [DATA_W-1:0]                   tap_s1,
	output logic                                match_s1
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [XW-1:0] SLOT = XW'(IDX + 1);

	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              at_pos;
	logic              after_pos;
	logic              in_use;
	logic [DATA_W-1:0] elem_q;

	assign pos_x     = XW'(cmd.pos);
	assign cnt_x     = XW'(count);
	assign at_pos    = (SLOT == pos_x);
	assign after_pos = (SLOT > pos_x);
	assign in_use    = (SLOT <= cnt_x);
	assign elem      = elem_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (after_pos) begin
				elem_q <= left;
			end else if (at_pos) begin
				elem_q <= cmd.value;
			end
		end else if (cmd.del && (at_pos || after_pos)) begin
			elem_q <= right;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tap_s1   <= at_pos ? elem_q : '0;
			match_s1 <= in_use && (elem_q == cmd.value);
		end
	end

endmodule

// File: design/positional_list_engine.sv
// A request is registered in the search stage, then in the output register that drives the m_ group.
// Throughput: one transaction per cycle unless the output stalls; elements shift and compare in all cells at once.
// The search stage and an output register part the two sides, so a stalled result
// still lets the next request in while the search stage is free.
// Reset clears the element count and all valid flags; element storage is not cleared.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero[39:38]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], data_out[33:2], found_position[39:34],
	                               // list_length[45:40], zero[47:46]
);

	`include "positional_list_engine_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [REQ_W-1:0]  req;
	logic [POS_W-1:0]  pos;
	logic [DATA_W-1:0] value;
	logic              accept;
	logic              advance;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              pos_ok;
	logic              ins_pos_ok;
	logic              full;
	logic              ins_ok;
	logic              del_ok;
	logic [ST_W-1:0]   status_nxt;
	logic              data_en_nxt;

	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [ST_W-1:0]   status_s1;
	logic              data_en_s1;
	logic [POS_W-1:0]  len_s1;

	ple_cmd_t          cmd;
	logic [DATA_W-1:0] elem_w  [CAPACITY];
	logic [DATA_W-1:0] tap_w   [CAPACITY];
	logic [CAPACITY-1:0] match_w;

	logic [DATA_W-1:0] tap_or;
	logic [XW-1:0]     found_x;
	logic              hit;
	logic [ST_W-1:0]   status_out;
	logic [DATA_W-1:0] data_out;
	logic [POS_W-1:0]  found_out;

	logic              out_valid_q;
	logic [47:0]       out_data_q;

	assign req   = s_tuser;
	assign pos   = s_tdata[5:0];
	assign value = s_tdata[37:6];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign pos_x      = XW'(pos);
	assign cnt_x      = XW'(count_q);
	assign pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
	assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
	assign full       = (cnt_x >= XW'(CAPACITY));
	assign ins_ok     = (req == REQ_INSERT) && ins_pos_ok && !full;
	assign del_ok     = (req == REQ_DELETE) && pos_ok;

	always_comb begin
		status_nxt  = ST_OK;
		data_en_nxt = 1'b0;
		count_nxt   = count_q;
		unique case (req)
			REQ_GET: begin
				data_en_nxt = pos_ok;
				status_nxt  = pos_ok ? ST_OK : ST_BADPOS;
			end
			REQ_LOCATE: begin
				status_nxt = ST_NOTFOUND;
			end
			REQ_INSERT: begin
				if (!ins_pos_ok) begin
					status_nxt = ST_BADPOS;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			REQ_DELETE: begin
				data_en_nxt = pos_ok;
				if (pos_ok) begin
					count_nxt = count_q - CW'(1);
				end else begin
					status_nxt = ST_BADPOS;
				end
			end
			REQ_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	assign cmd.ins   = accept && ins_ok;
	assign cmd.del   = accept && del_ok;
	assign cmd.load  = accept;
	assign cmd.pos   = pos;
	assign cmd.value = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_left
			assign left_w = elem_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = elem_w[i];
		end else begin : g_right
			assign right_w = elem_w[i+1];
		end
		ple_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count_q),
			.left     (left_w),
			.right    (right_w),
			.elem     (elem_w[i]),
			.tap_s1   (tap_w[i]),
			.match_s1 (match_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nxt;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req;
			status_s1  <= status_nxt;
			data_en_s1 <= data_en_nxt;
			len_s1     <= POS_W'(count_nxt);
		end
	end

	always_comb begin
		tap_or  = '0;
		found_x = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | tap_w[i];
		end
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match_w[i]) begin
				found_x = XW'(i + 1);
			end
		end
	end

	assign hit = |match_w;

	always_comb begin
		status_out = status_s1;
		found_out  = '0;
		if (req_s1 == REQ_LOCATE) begin
			status_out = hit ? ST_OK : ST_NOTFOUND;
			found_out  = hit ? POS_W'(found_x) : '0;
		end
	end

	assign data_out = data_en_s1 ? tap_or : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, len_s1, found_out, data_out, status_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`PLE_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "count exceeds capacity")
	`PLE_ASSERT_NEXT(a_s1_hold, valid_s1 && out_valid_q && !m_tready, valid_s1,
		"search stage dropped a stalled transaction")
	`PLE_ASSERT_NEXT(a_insert_grows, accept && ins_ok, count_q == $past(count_q) + CW'(1),
		"insert did not grow the list")
	`PLE_ASSERT(a_miss_zero, !(out_valid_q && (m_tdata[1:0] == ST_NOTFOUND)) ||
		(m_tdata[39:34] == '0), "miss reported with a position")

endmodule

// File: verif/positional_list_engine_tb.sv
// Self-checking testbench for positional_list_engine: directed and random list requests
// on the stream ports, each reply checked against a mirrored list. Depends on ple_pkg.
`timescale 1ns / 100ps

module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_C = 3'd7;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  found_pos;
		logic [POS_W-1:0]  list_length;
	} list_reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position[5:0], value[37:6], zero[39:38]
	logic [2:0]  s_tuser;   // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // status[1:0], data_out[33:2], found_position[39:34],
	                        // list_length[45:40], zero[47:46]

	logic [DATA_W-1:0] list_mirror [CAP];
	int                list_len;
	list_reply_t       expected_replies [$];

	int  mismatch_count;
	int  requests_taken;
	int  replies_checked;
	int  badpos_seen;
	int  full_seen;
	int  notfound_seen;
	int  input_stall_cycles;
	bit  src_gaps;
	bit  sink_gaps;
	int  sink_hold;

	positional_list_engine #(.CAPACITY(CAP)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("[positional_list_engine] ERROR");
		$finish;
	end

	function automatic list_reply_t predict_list_request(logic [2:0] req, logic [5:0] pos,
			logic [31:0] val);
		list_reply_t r;
		int          k;
		int          p;
		bit          hit;
		r = '0;
		r.status = ST_OK;
		p = pos;
		hit = 1'b0;
		case (req)
			REQ_GET: begin
				if (p >= 1 && p <= list_len)
					r.data = list_mirror[p-1];
				else
					r.status = ST_BADPOS;
			end
			REQ_LOCATE: begin
				for (k = 0; k < list_len; k++)
					if (!hit && list_mirror[k] == val) begin
						hit = 1'b1;
						r.found_pos = 6'(k + 1);
					end
				r.status = hit ? ST_OK : ST_NOTFOUND;
			end
			REQ_INSERT: begin
				if (p < 1 || p > list_len + 1)
					r.status = ST_BADPOS;
				else if (list_len >= CAP)
					r.status = ST_FULL;
				else begin
					for (k = list_len; k > p - 1; k--)
						list_mirror[k] = list_mirror[k-1];
					list_mirror[p-1] = val;
					list_len++;
				end
			end
			REQ_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					r.data = list_mirror[p-1];
					for (k = p - 1; k + 1 < list_len; k++)
						list_mirror[k] = list_mirror[k+1];
					list_len--;
				end else
					r.status = ST_BADPOS;
			end
			REQ_CLEAR: list_len = 0;
			default: ;
		endcase
		r.list_length = 6'(list_len);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin : scoreboard
		list_reply_t got;
		list_reply_t want;
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				input_stall_cycles++;
			if (s_tvalid && s_tready) begin
				expected_replies.push_back(predict_list_request(s_tuser, s_tdata[5:0],
					s_tdata[37:6]));
				requests_taken++;
			end
			if (m_tvalid && m_tready) begin
				got.status      = m_tdata[1:0];
				got.data        = m_tdata[33:2];
				got.found_pos   = m_tdata[39:34];
				got.list_length = m_tdata[45:40];
				if (expected_replies.size() == 0)
					report_mismatch("reply with no request outstanding");
				else begin
					want = expected_replies.pop_front();
					if (got.status != want.status)
						report_mismatch($sformatf("reply %0d status %0d, want %0d",
							replies_checked, got.status, want.status));
					if (got.data != want.data)
						report_mismatch($sformatf("reply %0d data_out %h, want %h",
							replies_checked, got.data, want.data));
					if (got.found_pos != want.found_pos)
						report_mismatch($sformatf("reply %0d found_position %0d, want %0d",
							replies_checked, got.found_pos, want.found_pos));
					if (got.list_length != want.list_length)
						report_mismatch($sformatf("reply %0d list_length %0d, want %0d",
							replies_checked, got.list_length, want.list_length));
				end
				case (got.status)
					ST_BADPOS:   badpos_seen++;
					ST_FULL:     full_seen++;
					ST_NOTFOUND: notfound_seen++;
					default: ;
				endcase
				replies_checked++;
			end
		end
	end

	initial begin : reply_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_gaps ? $urandom_range(0, 13) : 0;
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_request(input logic [2:0] req, input logic [5:0] pos,
			input logic [31:0] val);
		int gap;
		gap = src_gaps ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = {2'b00, val, pos};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (expected_replies.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			default: return 32'h0000_0000;
		endcase
	endfunction

	task automatic send_random_request();
		int          roll;
		int          ins_weight;
		logic [2:0]  req;
		logic [5:0]  pos;
		logic [31:0] val;
		roll = $urandom_range(0, 99);
		ins_weight = (list_len >= CAP - 3) ? 20 : 40;
		if (roll < 2)
			req = REQ_CLEAR;
		else if (roll < 5)
			req = 3'($urandom_range(int'(REQ_RSVD_A), int'(REQ_RSVD_C)));
		else if (roll < 5 + ins_weight)
			req = REQ_INSERT;
		else if (roll < 27 + ins_weight)
			req = REQ_DELETE;
		else if (roll < 47 + ins_weight)
			req = REQ_GET;
		else
			req = REQ_LOCATE;

		if ($urandom_range(0, 9) == 0)
			pos = 6'($urandom_range(0, 63));
		else if (req == REQ_INSERT)
			pos = 6'($urandom_range(1, list_len + 1));
		else if (list_len > 0)
			pos = 6'($urandom_range(1, list_len));
		else
			pos = 6'($urandom_range(0, 63));

		roll = $urandom_range(0, 9);
		if (req == REQ_LOCATE && list_len > 0 && roll < 7)
			val = list_mirror[$urandom_range(0, list_len - 1)];
		else if (roll < 3)
			val = 32'($urandom_range(0, 7));
		else if (roll == 3)
			val = pick_extreme();
		else
			val = $urandom;
		send_request(req, pos, val);
	endtask

	task automatic test_directed_edges();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		send_request(REQ_GET, 6'd0, 32'd0);
		send_request(REQ_GET, 6'd1, 32'd0);
		send_request(REQ_DELETE, 6'd1, 32'd0);
		send_request(REQ_LOCATE, 6'd0, 32'd0);
		send_request(REQ_INSERT, 6'd0, 32'h1111_1111);
		send_request(REQ_INSERT, 6'd2, 32'h2222_2222);
		send_request(REQ_INSERT, 6'd1, 32'h8000_0000);
		send_request(REQ_INSERT, 6'd2, 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 6'd1, 32'h0000_0000);
		send_request(REQ_INSERT, 6'd4, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 6'd63, 32'h3333_3333);
		send_request(REQ_GET, 6'd1, 32'hFFFF_FFFF);
		send_request(REQ_GET, 6'd4, 32'h0);
		send_request(REQ_GET, 6'd63, 32'h0);
		send_request(REQ_LOCATE, 6'd63, 32'h7FFF_FFFF);
		send_request(REQ_LOCATE, 6'd0, 32'h1234_5678);
		send_request(REQ_INSERT, 6'd3, 32'h0000_0000);
		send_request(REQ_LOCATE, 6'd0, 32'h0000_0000);
		send_request(REQ_DELETE, 6'd2, 32'h0);
		send_request(REQ_DELETE, 6'd4, 32'h0);
		send_request(REQ_DELETE, 6'd0, 32'hFFFF_FFFF);
		send_request(REQ_RSVD_A, 6'd21, 32'hA5A5_A5A5);
		send_request(REQ_RSVD_B, 6'd42, 32'h5A5A_5A5A);
		send_request(REQ_RSVD_C, 6'd63, 32'hFFFF_FFFF);
		send_request(REQ_CLEAR, 6'd0, 32'h0);
		send_request(REQ_GET, 6'd1, 32'h0);
	endtask

	task automatic test_full_list();
		src_gaps = 1'b1;
		sink_gaps = 1'b0;
		while (list_len < CAP)
			send_request(REQ_INSERT, 6'($urandom_range(1, list_len + 1)), $urandom);
		send_request(REQ_INSERT, 6'($urandom_range(1, CAP)), $urandom);
		send_request(REQ_INSERT, 6'(CAP + 1), 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 6'(CAP + 2), 32'h8000_0000);
		send_request(REQ_INSERT, 6'd63, 32'h0);
		send_request(REQ_GET, 6'(CAP), 32'h0);
		send_request(REQ_GET, 6'(CAP + 1), 32'h0);
		send_request(REQ_LOCATE, 6'd0, list_mirror[CAP-1]);
		send_request(REQ_DELETE, 6'(CAP), 32'h0);
		send_request(REQ_INSERT, 6'(CAP), 32'h8000_0000);
		send_request(REQ_DELETE, 6'd1, 32'h0);
		repeat (4)
			send_request(REQ_DELETE, 6'($urandom_range(1, list_len)), 32'h0);
	endtask

	task automatic test_output_backpressure();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		sink_hold = 300;
		repeat (40)
			send_random_request();
	endtask

	task automatic test_drain_pause();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (20)
			send_random_request();
		wait_drained();
		repeat (20)
			send_random_request();
	endtask

	task automatic test_random_traffic();
		int burst;
		for (burst = 0; burst < 12; burst++) begin
			src_gaps  = (burst % 4) inside {0, 1};
			sink_gaps = (burst % 4) inside {0, 2};
			repeat (40)
				send_random_request();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		list_len = 0;
		mismatch_count = 0;
		requests_taken = 0;
		replies_checked = 0;
		badpos_seen = 0;
		full_seen = 0;
		notfound_seen = 0;
		input_stall_cycles = 0;
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		sink_hold = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_full_list();
		test_output_backpressure();
		test_drain_pause();
		test_random_traffic();

		wait_drained();
		repeat (8) @(negedge clk);
		if (expected_replies.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

		$display("Checked %0d replies to %0d requests: %0d bad position, %0d list full, %0d not found.",
			replies_checked, requests_taken, badpos_seen, full_seen, notfound_seen);
		$display("Input stalled %0d cycles under output backpressure; %0d mismatches.",
			input_stall_cycles, mismatch_count);
		if (mismatch_count == 0)
			$display("[positional_list_engine] OK");
		else
			$display("[positional_list_engine] ERROR");
		$finish;
	end

endmodule
